@@ design/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types and constants of the integer to ascii formatter: selector
// codes, digit shifter control, and the digit to character mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned MAG_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned SH_W       = 64;
  localparam int unsigned CNT_W      = 6;

  localparam logic [CNT_W-1:0] DIGS_DEC = 6'd10;
  localparam logic [CNT_W-1:0] DIGS_BIN = 6'd32;
  localparam logic [CNT_W-1:0] DIGS_OCT = 6'd11;
  localparam logic [CNT_W-1:0] DIGS_HEX = 6'd8;
  localparam logic [CNT_W-1:0] DIGS_PTR = 6'd16;

  localparam logic [6:0] DIGIT_BASE = 7'd48;
  localparam logic [6:0] LOWER_GAP  = 7'd39;
  localparam logic [6:0] UPPER_GAP  = 7'd7;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_BIN  = 3'd2,
    CMD_OCT  = 3'd3,
    CMD_HEXL = 3'd4,
    CMD_HEXU = 3'd5,
    CMD_PTR  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    DW_1 = 2'd0,
    DW_3 = 2'd1,
    DW_4 = 2'd2
  } dig_w_e;

  typedef struct packed {
    logic             load;
    logic             shift;
    dig_w_e           width;
    logic [CNT_W-1:0] ndig;
    logic [SH_W-1:0]  data;
  } sh_ctl_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       last;
  } sh_stat_t;

  function automatic logic [6:0] digit_char(logic [3:0] d, logic upper);
    logic [6:0] c;
    c = DIGIT_BASE + {3'b000, d};
    if (d > 4'd9) begin
      c = c + (upper ? UPPER_GAP : LOWER_GAP);
    end
    return c;
  endfunction

endpackage

@@ design/i2a_dabble.sv @@
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial binary to bcd converter: shifts the 32-bit magnitude in one bit
// per cycle, adding three to every bcd digit of five or more before each shift.
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [i2a_pkg::MAG_W-1:0]     mag_i,
  output logic                          done_o,
  output logic [i2a_pkg::BCD_W-1:0]     bcd_o
);

  localparam int unsigned STEP_W = $clog2(i2a_pkg::MAG_W);

  logic [i2a_pkg::MAG_W-1:0] bin_q, bin_d;
  logic [i2a_pkg::BCD_W-1:0] bcd_q, bcd_d, adj;
  logic [STEP_W-1:0]         step_q, step_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < int'(i2a_pkg::BCD_DIGITS); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      step_d = STEP_W'(i2a_pkg::MAG_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d  = {adj[i2a_pkg::BCD_W-2:0], bin_q[i2a_pkg::MAG_W-1]};
      bin_d  = {bin_q[i2a_pkg::MAG_W-2:0], 1'b0};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

@@ design/i2a_dshift.sv @@
// ----------------------------------------------------------------------------
// i2a_dshift
// Digit shift register: holds the left-justified digit field and hands out
// the top digit of one, three or four bits, one digit per shift.
// ----------------------------------------------------------------------------
module i2a_dshift (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2a_pkg::sh_ctl_t    ctl_i,
  output i2a_pkg::sh_stat_t   stat_o
);

  logic [i2a_pkg::SH_W-1:0]  sh_q, sh_d, shifted;
  logic [i2a_pkg::CNT_W-1:0] cnt_q, cnt_d;
  i2a_pkg::dig_w_e           width_q, width_d;
  logic [3:0]                digit;

  always_comb begin
    unique case (width_q)
      i2a_pkg::DW_1: begin
        digit   = {3'b000, sh_q[i2a_pkg::SH_W-1]};
        shifted = {sh_q[i2a_pkg::SH_W-2:0], 1'b0};
      end
      i2a_pkg::DW_3: begin
        digit   = {1'b0, sh_q[i2a_pkg::SH_W-1 -: 3]};
        shifted = {sh_q[i2a_pkg::SH_W-4:0], 3'b000};
      end
      default: begin
        digit   = sh_q[i2a_pkg::SH_W-1 -: 4];
        shifted = {sh_q[i2a_pkg::SH_W-5:0], 4'b0000};
      end
    endcase
  end

  always_comb begin
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    width_d = width_q;
    if (ctl_i.load) begin
      sh_d    = ctl_i.data;
      cnt_d   = ctl_i.ndig;
      width_d = ctl_i.width;
    end else if (ctl_i.shift) begin
      sh_d  = shifted;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q    <= sh_d;
    width_q <= width_d;
  end

  assign stat_o.digit = digit;
  assign stat_o.last  = (cnt_q == i2a_pkg::CNT_W'(1));

endmodule

@@ design/integer_to_ascii_formatter_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one number per input word as a stream of ascii characters, one
// character per output word, most significant digit first.
// ----------------------------------------------------------------------------
// One number is worked on at a time; in_stall_o stays high from acceptance
// until the last character sits in the output register. Decimal numbers first
// pass through the bit-serial binary to bcd converter, then the ten bcd digits
// are walked most significant first with leading zeros skipped. Binary walks
// all 32 bit positions, octal 11 digits, hex 8 digits, pointer "0x" plus 16
// digits, and a zero pointer prints "(nil)". A stalled output holds back the
// next character. Selector value 7 is accepted and produces no characters.
module integer_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  char_code_o,
  output logic        last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PRE,
    ST_DIG
  } state_e;

  typedef enum logic [1:0] {
    PRE_MINUS,
    PRE_HEX,
    PRE_NIL
  } pre_e;

  function automatic logic [6:0] pre_char(pre_e k, logic [2:0] idx);
    logic [6:0] c;
    unique case (k)
      PRE_MINUS: c = 7'h2d;
      PRE_HEX:   c = (idx == 3'd0) ? 7'h30 : 7'h78;
      default: begin
        unique case (idx)
          3'd0:    c = 7'h28;
          3'd1:    c = 7'h6e;
          3'd2:    c = 7'h69;
          3'd3:    c = 7'h6c;
          default: c = 7'h29;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pre_end(pre_e k);
    logic [2:0] n;
    unique case (k)
      PRE_MINUS: n = 3'd0;
      PRE_HEX:   n = 3'd1;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  state_e     state_q, state_d;
  pre_e       pre_q, pre_d;
  logic [2:0] pre_idx_q, pre_idx_d;
  logic       neg_q, neg_d;
  logic       upper_q, upper_d;
  logic       started_q, started_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;

  logic                          accept;
  logic                          out_free;
  logic                          emit;
  logic [31:0]                   low;
  logic [i2a_pkg::MAG_W-1:0]     mag;
  logic                          dab_start;
  logic                          dab_done;
  logic [i2a_pkg::BCD_W-1:0]     bcd;
  i2a_pkg::sh_ctl_t              sh_ctl;
  i2a_pkg::sh_stat_t             sh_stat;

  assign low    = value_i[31:0];
  assign mag    = (cmd_i == i2a_pkg::CMD_SDEC && low[31]) ? (32'd0 - low) : low;
  assign accept = in_valid_i && (state_q == ST_IDLE);
  // output register can take a word when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  i2a_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .mag_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (bcd)
  );

  i2a_dshift u_dshift (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sh_ctl),
    .stat_o (sh_stat)
  );

  always_comb begin
    state_d     = state_q;
    pre_d       = pre_q;
    pre_idx_d   = pre_idx_q;
    neg_d       = neg_q;
    upper_d     = upper_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    emit        = 1'b0;
    dab_start   = 1'b0;
    sh_ctl      = '{load: 1'b0, shift: 1'b0, width: i2a_pkg::DW_4,
                    ndig: '0, data: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          started_d = 1'b0;
          upper_d   = (cmd_i == i2a_pkg::CMD_HEXU);
          pre_idx_d = '0;
          unique case (cmd_i)
            i2a_pkg::CMD_SDEC, i2a_pkg::CMD_UDEC: begin
              dab_start = 1'b1;
              neg_d     = (cmd_i == i2a_pkg::CMD_SDEC) && low[31];
              pre_d     = PRE_MINUS;
              state_d   = ST_CONV;
            end
            i2a_pkg::CMD_BIN: begin
              sh_ctl.load  = 1'b1;
              sh_ctl.width = i2a_pkg::DW_1;
              sh_ctl.ndig  = i2a_pkg::DIGS_BIN;
              sh_ctl.data  = {low, 32'd0};
              state_d      = ST_DIG;
            end
            i2a_pkg::CMD_OCT: begin
              // 33-bit field so the top octal digit holds only two bits
              sh_ctl.load  = 1'b1;
              sh_ctl.width = i2a_pkg::DW_3;
              sh_ctl.ndig  = i2a_pkg::DIGS_OCT;
              sh_ctl.data  = {1'b0, low, 31'd0};
              state_d      = ST_DIG;
            end
            i2a_pkg::CMD_HEXL, i2a_pkg::CMD_HEXU: begin
              sh_ctl.load  = 1'b1;
              sh_ctl.width = i2a_pkg::DW_4;
              sh_ctl.ndig  = i2a_pkg::DIGS_HEX;
              sh_ctl.data  = {low, 32'd0};
              state_d      = ST_DIG;
            end
            i2a_pkg::CMD_PTR: begin
              state_d = ST_PRE;
              if (value_i == 64'd0) begin
                pre_d = PRE_NIL;
              end else begin
                pre_d        = PRE_HEX;
                sh_ctl.load  = 1'b1;
                sh_ctl.width = i2a_pkg::DW_4;
                sh_ctl.ndig  = i2a_pkg::DIGS_PTR;
                sh_ctl.data  = value_i;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_CONV: begin
        if (dab_done) begin
          sh_ctl.load  = 1'b1;
          sh_ctl.width = i2a_pkg::DW_4;
          sh_ctl.ndig  = i2a_pkg::DIGS_DEC;
          sh_ctl.data  = {bcd, 24'd0};
          state_d      = neg_q ? ST_PRE : ST_DIG;
        end
      end

      ST_PRE: begin
        if (out_free) begin
          emit      = 1'b1;
          char_d    = pre_char(pre_q, pre_idx_q);
          last_d    = (pre_q == PRE_NIL) && (pre_idx_q == pre_end(pre_q));
          pre_idx_d = pre_idx_q + 1'b1;
          if (pre_idx_q == pre_end(pre_q)) begin
            state_d = (pre_q == PRE_NIL) ? ST_IDLE : ST_DIG;
          end
        end
      end

      default: begin
        // leading zeros are dropped, but the final digit always prints
        if (sh_stat.digit == 4'd0 && !started_q && !sh_stat.last) begin
          sh_ctl.shift = 1'b1;
        end else if (out_free) begin
          emit         = 1'b1;
          char_d       = i2a_pkg::digit_char(sh_stat.digit, upper_q);
          last_d       = sh_stat.last;
          sh_ctl.shift = 1'b1;
          started_d    = 1'b1;
          if (sh_stat.last) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pre_q       <= PRE_MINUS;
      pre_idx_q   <= '0;
      neg_q       <= 1'b0;
      upper_q     <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pre_q       <= pre_d;
      pre_idx_q   <= pre_idx_d;
      neg_q       <= neg_d;
      upper_q     <= upper_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> state_q == ST_CONV)
    else $error("converter finished outside conversion state");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> state_q == ST_IDLE)
    else $error("final character emitted but item still running");

  a_pre_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRE |-> pre_idx_q <= pre_end(pre_q))
    else $error("prefix index ran past its text");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("character written over an untaken word");
`endif

endmodule

@@ dv/integer_to_ascii_formatter_top_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top_tb
// Self-checking bench for the integer to ascii formatter. Numbers are pushed
// with random pacing, and every character that comes out is checked against
// a string built from the number and the selector.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_WAIT  = 60;
  localparam int unsigned RAND_ITEMS = 200;
  localparam logic [2:0]  CMD_NONE   = 3'd7;

  class char_scoreboard;
    typedef struct {
      logic [6:0] code;
      logic       last;
    } char_word_t;

    char_word_t pending_chars[$];
    int         errors;
    int         mismatches;

    function new();
      errors     = 0;
      mismatches = 0;
    endfunction

    function automatic logic [6:0] digit_code(logic [3:0] d, logic upper);
      if (d < 4'd10) return 7'h30 + 7'(d);
      return (upper ? 7'h41 : 7'h61) + 7'(d) - 7'd10;
    endfunction

    // most significant digit first, zero gives a single '0'
    function automatic void push_digits(ref logic [6:0] s[$], input logic [63:0] mag,
                                        input logic [63:0] radix, input logic upper);
      logic [6:0] rev[$];
      if (mag == 64'd0) begin
        s.push_back(7'h30);
        return;
      end
      while (mag != 64'd0) begin
        rev.push_front(digit_code(4'(mag % radix), upper));
        mag = mag / radix;
      end
      foreach (rev[i]) s.push_back(rev[i]);
    endfunction

    function automatic void format_number(logic [2:0] cmd, logic [63:0] value);
      logic [6:0] s[$];
      logic [31:0] low;
      low = value[31:0];
      case (cmd)
        i2a_pkg::CMD_SDEC: begin
          if (low[31]) begin
            s.push_back(7'h2d);
            push_digits(s, {32'd0, 32'd0 - low}, 64'd10, 1'b0);
          end else begin
            push_digits(s, {32'd0, low}, 64'd10, 1'b0);
          end
        end
        i2a_pkg::CMD_UDEC: push_digits(s, {32'd0, low}, 64'd10, 1'b0);
        i2a_pkg::CMD_BIN:  push_digits(s, {32'd0, low}, 64'd2, 1'b0);
        i2a_pkg::CMD_OCT:  push_digits(s, {32'd0, low}, 64'd8, 1'b0);
        i2a_pkg::CMD_HEXL: push_digits(s, {32'd0, low}, 64'd16, 1'b0);
        i2a_pkg::CMD_HEXU: push_digits(s, {32'd0, low}, 64'd16, 1'b1);
        i2a_pkg::CMD_PTR: begin
          if (value == 64'd0) begin
            s = '{7'h28, 7'h6e, 7'h69, 7'h6c, 7'h29};
          end else begin
            s.push_back(7'h30);
            s.push_back(7'h78);
            push_digits(s, value, 64'd16, 1'b0);
          end
        end
        default: ;
      endcase
      foreach (s[i]) pending_chars.push_back('{code: s[i], last: (i == s.size() - 1)});
    endfunction

    function automatic void check_char(logic [6:0] code, logic last);
      char_word_t exp_w;
      if (pending_chars.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected char word: code %0d last %0b", code, last);
        mismatches++;
        return;
      end
      exp_w = pending_chars.pop_front();
      if (code !== exp_w.code || last !== exp_w.last) begin
        errors++;
        if (mismatches < 10)
          $display("char mismatch: expected code %0d last %0b, got code %0d last %0b",
                   exp_w.code, exp_w.last, code, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i       = 3'd0;
  logic [63:0] value_i     = 64'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [6:0]  char_code_o;
  logic        last_o;

  char_scoreboard sb = new();
  bit          tx_pace = 1'b1;
  bit          rx_pace = 1'b1;
  int unsigned idle_cycles = 0;

  integer_to_ascii_formatter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // monitors see pre-edge values, so ordering against the drivers is fixed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.format_number(cmd_i, value_i);
      if (out_valid_o && !out_stall_i) sb.check_char(char_code_o, last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("integer_to_ascii_formatter_top test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stall before each word, none while rx_pace is off
  initial begin
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      hold = rx_pace ? $urandom_range(0, 19) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  task automatic send_number(logic [2:0] cmd, logic [63:0] value);
    int unsigned gap;
    gap = tx_pace ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      cmd_i      <= 3'($urandom());
      value_i    <= {$urandom(), $urandom()};
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold off the sender until every outstanding character has come back
  task automatic drain_chars();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_chars.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0: return {$urandom(), $urandom()};
      1: return {$urandom(), 32'($urandom_range(0, 99))};
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      4: return {$urandom(), 32'h8000_0000 | 32'($urandom_range(0, 3))};
      5: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
      default: return 64'd0;
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned phase;
    logic [2:0]  cmd;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of every selector, sign handling and nil pointer
    send_number(i2a_pkg::CMD_SDEC, 64'd0);
    send_number(i2a_pkg::CMD_SDEC, 64'd1);
    send_number(i2a_pkg::CMD_SDEC, 64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CMD_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
    send_number(i2a_pkg::CMD_SDEC, 64'h1234_5678_8000_0000);
    send_number(i2a_pkg::CMD_UDEC, 64'd0);
    send_number(i2a_pkg::CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_UDEC, 64'hDEAD_BEEF_0000_000A);
    send_number(i2a_pkg::CMD_BIN,  64'd0);
    send_number(i2a_pkg::CMD_BIN,  64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CMD_BIN,  64'hFFFF_FFFF_8000_0000);
    send_number(i2a_pkg::CMD_OCT,  64'd0);
    send_number(i2a_pkg::CMD_OCT,  64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_HEXL, 64'd0);
    send_number(i2a_pkg::CMD_HEXL, 64'h0000_0001_89AB_CDEF);
    send_number(i2a_pkg::CMD_HEXU, 64'h0000_0000_00AB_CDEF);
    send_number(i2a_pkg::CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_PTR,  64'd0);
    send_number(i2a_pkg::CMD_PTR,  64'd1);
    send_number(i2a_pkg::CMD_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_PTR,  64'h0000_0001_0000_0000);
    send_number(CMD_NONE, {$urandom(), $urandom()});
    drain_chars();

    n = 0;
    while (n < RAND_ITEMS) begin
      // pacing alternates between both idling, one side idling and none
      phase   = (n / 40) % 4;
      tx_pace = (phase & 1) == 0;
      rx_pace = (phase & 2) == 0;
      pick    = $urandom_range(0, 31);
      cmd     = (pick < 28) ? 3'(pick % 7) : CMD_NONE;
      send_number(cmd, pick_value());
      if (cmd != CMD_NONE) n++;
      if (n == RAND_ITEMS / 2 && cmd != CMD_NONE) drain_chars();
    end
    in_valid_i <= 1'b0;
    tx_pace = 1'b1;
    rx_pace = 1'b1;

    @(posedge clk_i);
    while (sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
      $display("integer_to_ascii_formatter_top test passed");
    end else begin
      $display("integer_to_ascii_formatter_top test failed");
    end
    $finish;
  end

endmodule
